FILE: hdl/scaled_ns_time_alu_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scaled nanosecond time ALU.
// Each macro samples on the rising edge of clk and is off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCALED_NS_TIME_ALU_TOP_ASSERT_SVH
`define SCALED_NS_TIME_ALU_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TSA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Types and constants shared by the scaled nanosecond time ALU modules.
// ----------------------------------------------------------------------------
package tsa_pkg;

	localparam int unsigned NS_W       = 64;
	localparam int unsigned PART_W     = 16;
	localparam int unsigned SEC_W      = 32;
	localparam int unsigned NANO_W     = 30;
	localparam int unsigned PROD_W     = SEC_W + NANO_W;
	localparam int unsigned QUO_W      = 35;
	localparam int unsigned DIV_STEPS  = 5;
	localparam int unsigned DIV_STAGES = QUO_W / DIV_STEPS;

	localparam logic [NANO_W:0]   NS_PER_SEC   = 31'd1000000000;
	localparam logic [NANO_W-1:0] NS_PER_SEC_N = 30'd1000000000;

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_SUB   = 3'd1,
		CMD_HALVE = 3'd2,
		CMD_CMP   = 3'd3,
		CMD_TO_TS = 3'd4,
		CMD_FROM_TS = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ORD_EQ   = 2'd0,
		ORD_GT   = 2'd1,
		ORD_LT   = 2'd2
	} order_t;

	// Result fields that travel alongside the divider.
	typedef struct packed {
		logic [2:0]        cmd;
		logic [PART_W-1:0] hi;
		logic [NS_W-1:0]   ns;
		logic [PART_W-1:0] sub;
		logic [1:0]        order;
	} side_t;

	// Divider working state for one stage.
	typedef struct packed {
		logic [NANO_W-1:0] rem;
		logic [QUO_W-1:0]  bits;
		logic [QUO_W-1:0]  quo;
	} div_t;

endpackage

FILE: hdl/tsa_front.sv
// ----------------------------------------------------------------------------
// tsa_front
// First stage: 96-bit add, subtract, halve and compare, the seconds product
// for timestamp conversion, and the divider start state.
// ----------------------------------------------------------------------------
module tsa_front
	import tsa_pkg::*;
(
	input  logic                clk,
	input  logic                en,
	input  logic [2:0]          cmd,
	input  logic [PART_W-1:0]   a_high_ns,
	input  logic [NS_W-1:0]     a_ns,
	input  logic [PART_W-1:0]   a_sub_ns,
	input  logic [PART_W-1:0]   b_high_ns,
	input  logic [NS_W-1:0]     b_ns,
	input  logic [PART_W-1:0]   b_sub_ns,
	input  logic [SEC_W-1:0]    stamp_seconds_in,
	input  logic [NANO_W-1:0]   stamp_nanos_in,
	output side_t               side_s1,
	output div_t                div_s1,
	output logic [PROD_W-1:0]   prod_s1,
	output logic [NANO_W-1:0]   nanos_s1
);

	localparam int unsigned T_W = 2 * PART_W + NS_W;

	logic [T_W-1:0] ta, tb, tr;
	side_t          side_d;

	assign ta = {a_high_ns, a_ns, a_sub_ns};
	assign tb = {b_high_ns, b_ns, b_sub_ns};

	always_comb begin
		tr     = '0;
		side_d = '0;
		side_d.cmd = cmd;
		case (cmd)
			CMD_ADD:   tr = ta + tb;
			CMD_SUB:   tr = ta - tb;
			CMD_HALVE: tr = ta >> 1;
			CMD_CMP: begin
				if (ta > tb)
					side_d.order = ORD_GT;
				else if (ta < tb)
					side_d.order = ORD_LT;
				else
					side_d.order = ORD_EQ;
			end
			default: tr = '0;
		endcase
		side_d.hi  = tr[T_W-1 -: PART_W];
		side_d.ns  = tr[PART_W +: NS_W];
		side_d.sub = tr[PART_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1       <= side_d;
			prod_s1       <= PROD_W'(stamp_seconds_in) * PROD_W'(NS_PER_SEC_N);
			nanos_s1      <= stamp_nanos_in;
			div_s1.rem    <= NANO_W'(a_ns[NS_W-1:QUO_W]);
			div_s1.bits   <= a_ns[QUO_W-1:0];
			div_s1.quo    <= '0;
		end
	end

endmodule

FILE: hdl/tsa_div_stage.sv
// ----------------------------------------------------------------------------
// tsa_div_stage
// One stage of the restoring divider by one billion: five quotient bits.
// ----------------------------------------------------------------------------
module tsa_div_stage
	import tsa_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  div_t div_in,
	output div_t div_q
);

	div_t           nxt;
	logic [NANO_W:0] trial;
	logic            ge;

	always_comb begin
		nxt   = div_in;
		trial = '0;
		ge    = 1'b0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial    = {nxt.rem, nxt.bits[QUO_W-1]};
			nxt.bits = nxt.bits << 1;
			ge       = trial >= NS_PER_SEC;
			nxt.rem  = ge ? NANO_W'(trial - NS_PER_SEC) : trial[NANO_W-1:0];
			nxt.quo  = {nxt.quo[QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_q <= nxt;
		end
	end

endmodule

FILE: hdl/scaled_ns_time_alu_top.sv
// ----------------------------------------------------------------------------
// scaled_ns_time_alu_top
// Pipelined ALU for 96-bit scaled nanosecond times and message timestamps.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while in_stall is low and
// returns exactly one result transaction for each, in order. The depth of
// the pipeline is set by the divider that splits a nanosecond count into
// seconds and nanoseconds: it is a restoring divider by one billion that
// forms five quotient bits in each of seven stages, behind one front stage
// that does the 96-bit add, subtract, halve and compare and the
// seconds-times-billion product. The whole pipeline advances together; when
// the last stage holds a result and out_stall is high, every stage holds and
// in_stall is raised, so nothing is lost or repeated. Fields that a command
// does not produce come back as zero, and unused command codes return a
// result with every field zero.
// ----------------------------------------------------------------------------
module scaled_ns_time_alu_top
	import tsa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          cmd,
	input  logic [PART_W-1:0]   a_high_ns,
	input  logic [NS_W-1:0]     a_ns,
	input  logic [PART_W-1:0]   a_sub_ns,
	input  logic [PART_W-1:0]   b_high_ns,
	input  logic [NS_W-1:0]     b_ns,
	input  logic [PART_W-1:0]   b_sub_ns,
	input  logic [SEC_W-1:0]    stamp_seconds_in,
	input  logic [NANO_W-1:0]   stamp_nanos_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [PART_W-1:0]   r_high_ns,
	output logic [NS_W-1:0]     r_ns,
	output logic [PART_W-1:0]   r_sub_ns,
	output logic [1:0]          order,
	output logic [SEC_W-1:0]    stamp_seconds_out,
	output logic [NANO_W-1:0]   stamp_nanos_out
);

	// One valid bit per stage: index 0 is the front stage.
	logic [DIV_STAGES:0] vld_s;
	logic                en;

	side_t             side_s1;
	div_t              div_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [NANO_W-1:0] nanos_s1;

	side_t side_s[DIV_STAGES];
	div_t  div_s[DIV_STAGES+1];

	side_t fixed_s1;
	side_t last_s;
	div_t  last_div;
	logic  to_ts;

	// The pipeline moves unless a finished result is waiting to be taken.
	assign en       = !(vld_s[DIV_STAGES] && out_stall);
	assign in_stall = vld_s[DIV_STAGES] && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DIV_STAGES-1:0], in_valid};
		end
	end

	tsa_front u_front (
		.clk              (clk),
		.en               (en),
		.cmd              (cmd),
		.a_high_ns        (a_high_ns),
		.a_ns             (a_ns),
		.a_sub_ns         (a_sub_ns),
		.b_high_ns        (b_high_ns),
		.b_ns             (b_ns),
		.b_sub_ns         (b_sub_ns),
		.stamp_seconds_in (stamp_seconds_in),
		.stamp_nanos_in   (stamp_nanos_in),
		.side_s1          (side_s1),
		.div_s1           (div_s1),
		.prod_s1          (prod_s1),
		.nanos_s1         (nanos_s1)
	);

	// The timestamp-to-time command finishes its sum in the second stage.
	always_comb begin
		fixed_s1 = side_s1;
		if (side_s1.cmd == CMD_FROM_TS) begin
			fixed_s1.ns = NS_W'(prod_s1) + NS_W'(nanos_s1);
		end
	end

	assign div_s[0] = div_s1;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		tsa_div_stage u_div (
			.clk    (clk),
			.en     (en),
			.div_in (div_s[g]),
			.div_q  (div_s[g+1])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g] <= (g == 0) ? fixed_s1 : side_s[(g == 0) ? 0 : g-1];
			end
		end
	end

	assign last_s   = side_s[DIV_STAGES-1];
	assign last_div = div_s[DIV_STAGES];
	assign to_ts    = last_s.cmd == CMD_TO_TS;

	assign out_valid = vld_s[DIV_STAGES];
	assign r_high_ns = last_s.hi;
	assign r_ns      = last_s.ns;
	assign r_sub_ns  = last_s.sub;
	assign order     = last_s.order;

	// Quotients that do not fit in 32 bits saturate.
	always_comb begin
		stamp_seconds_out = '0;
		stamp_nanos_out   = '0;
		if (to_ts) begin
			stamp_nanos_out = last_div.rem;
			if (last_div.quo[QUO_W-1:SEC_W] != '0)
				stamp_seconds_out = '1;
			else
				stamp_seconds_out = last_div.quo[SEC_W-1:0];
		end
	end

endmodule

FILE: hdl/tsa_checker.sv
// ----------------------------------------------------------------------------
// tsa_checker
// Port-level checks for the scaled nanosecond time ALU, bound to the top.
// ----------------------------------------------------------------------------
`include "scaled_ns_time_alu_top_assert.svh"

module tsa_checker
	import tsa_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic [PART_W-1:0]   r_high_ns,
	input logic [NS_W-1:0]     r_ns,
	input logic [PART_W-1:0]   r_sub_ns,
	input logic [1:0]          order,
	input logic [SEC_W-1:0]    stamp_seconds_out,
	input logic [NANO_W-1:0]   stamp_nanos_out
);

	`TSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(r_ns), "result dropped or changed while stalled")
	`TSA_ASSERT_SAME(a_order_code, out_valid, order != 2'd3, "invalid compare code")
	`TSA_ASSERT_SAME(a_nanos_range, out_valid, stamp_nanos_out < NS_PER_SEC_N, "nanoseconds not below one second")
	`TSA_ASSERT_SAME(a_cmp_only, out_valid && order != ORD_EQ, r_ns == '0 && r_high_ns == '0 && r_sub_ns == '0 && stamp_seconds_out == '0, "compare result mixed with other fields")
	`TSA_ASSERT_SAME(a_ts_only, out_valid && stamp_seconds_out != '0, r_ns == '0 && order == ORD_EQ, "timestamp result mixed with other fields")

endmodule

bind scaled_ns_time_alu_top tsa_checker u_tsa_checker (.*);

FILE: tb/sv/scaled_ns_time_alu_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scaled_ns_time_alu_top_tb
// Self-checking bench for the scaled nanosecond time ALU. Every accepted
// operation is predicted in the bench and compared against the result stream
// in order, while both handshakes are idled and stalled at random.
// ----------------------------------------------------------------------------
module scaled_ns_time_alu_top_tb;
	import tsa_pkg::*;

	// The two command codes that the package leaves unused.
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam longint unsigned BILLION = 64'd1000000000;
	localparam int RANDOM_OPS = 680;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 30;

	// One operation as it is presented on the input ports.
	typedef struct {
		logic [2:0]        op;
		logic [PART_W-1:0] ah;
		logic [NS_W-1:0]   an;
		logic [PART_W-1:0] as_;
		logic [PART_W-1:0] bh;
		logic [NS_W-1:0]   bn;
		logic [PART_W-1:0] bs;
		logic [SEC_W-1:0]  sec;
		logic [NANO_W-1:0] nano;
	} alu_op_t;

	// Every output field of one result transaction.
	typedef struct packed {
		logic [PART_W-1:0] hi;
		logic [NS_W-1:0]   ns;
		logic [PART_W-1:0] sub;
		logic [1:0]        ord;
		logic [SEC_W-1:0]  sec;
		logic [NANO_W-1:0] nano;
	} alu_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] cmd = '0;
	logic [PART_W-1:0] a_high_ns = '0, a_sub_ns = '0, b_high_ns = '0, b_sub_ns = '0;
	logic [NS_W-1:0] a_ns = '0, b_ns = '0;
	logic [SEC_W-1:0] stamp_seconds_in = '0;
	logic [NANO_W-1:0] stamp_nanos_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PART_W-1:0] r_high_ns, r_sub_ns;
	logic [NS_W-1:0] r_ns;
	logic [1:0] order;
	logic [SEC_W-1:0] stamp_seconds_out;
	logic [NANO_W-1:0] stamp_nanos_out;

	// Results that the block still owes us, oldest first.
	alu_result_t pending_results[$];
	int mismatches = 0;
	int results_seen = 0;
	int ops_sent = 0;
	int cycles = 0;
	// While set, neither side idles nor stalls.
	bit steady = 1'b0;

	scaled_ns_time_alu_top i_dut (.*);

	always #5 clk = ~clk;

	// Compute what the block must return for one operation. Add, subtract,
	// halve and compare are all plain arithmetic on the 96-bit concatenation.
	function automatic alu_result_t time_alu_result(alu_op_t o);
		logic [95:0] a, b, r;
		logic [63:0] q;
		alu_result_t res;
		a = {o.ah, o.an, o.as_};
		b = {o.bh, o.bn, o.bs};
		res = '0;
		case (o.op)
			CMD_ADD: begin
				r = a + b;
				{res.hi, res.ns, res.sub} = r;
			end
			CMD_SUB: begin
				r = a - b;
				{res.hi, res.ns, res.sub} = r;
			end
			CMD_HALVE: begin
				r = a >> 1;
				{res.hi, res.ns, res.sub} = r;
			end
			CMD_CMP: begin
				res.ord = (a == b) ? ORD_EQ : ((a > b) ? ORD_GT : ORD_LT);
			end
			CMD_TO_TS: begin
				q = o.an / BILLION;
				res.sec = (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
				res.nano = NANO_W'(o.an % BILLION);
			end
			CMD_FROM_TS: begin
				res.ns = 64'(o.sec) * BILLION + 64'(o.nano);
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic logic [63:0] rand_ns();
		return {$urandom(), $urandom()};
	endfunction

	// Sub-nanosecond parts near the carry boundary are the interesting ones.
	function automatic logic [15:0] rand_part();
		case ($urandom_range(3))
			0: return 16'hFFFF - 16'($urandom_range(2));
			1: return 16'($urandom_range(2));
			default: return 16'($urandom());
		endcase
	endfunction

	// Present one operation, hold it until accepted, and record its result.
	// Called at a falling edge; valid stays high afterwards so that the next
	// call can follow without a gap.
	task automatic send_op(alu_op_t o);
		while (!steady && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= o.op;
		a_high_ns <= o.ah;
		a_ns <= o.an;
		a_sub_ns <= o.as_;
		b_high_ns <= o.bh;
		b_ns <= o.bn;
		b_sub_ns <= o.bs;
		stamp_seconds_in <= o.sec;
		stamp_nanos_in <= o.nano;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		pending_results.push_back(time_alu_result(o));
		ops_sent++;
		@(negedge clk);
	endtask

	task automatic send_time_pair(logic [2:0] op, logic [95:0] a, logic [95:0] b);
		alu_op_t o;
		o = '{op, a[95:80], a[79:16], a[15:0], b[95:80], b[79:16], b[15:0], '0, '0};
		send_op(o);
	endtask

	task automatic send_stamp(logic [2:0] op, logic [63:0] an, logic [31:0] sec,
			logic [29:0] nano);
		alu_op_t o;
		o = '{op, 16'hFFFF, an, 16'hFFFF, '0, '0, '0, sec, nano};
		send_op(o);
	endtask

	// Carries and borrows across both part boundaries, wrap at 2^96, and the
	// sub-nanosecond sum that lands exactly on 0xFFFF without a carry.
	task automatic test_add_sub();
		send_time_pair(CMD_ADD, {16'h0, 64'h0, 16'h8000}, {16'h0, 64'h0, 16'h7FFF});
		send_time_pair(CMD_ADD, {16'h0, 64'h5, 16'hFFFF}, {16'h0, 64'h0, 16'h0001});
		send_time_pair(CMD_ADD, {16'h1, {64{1'b1}}, 16'hFFFF}, {16'h0, 64'h0, 16'h1});
		send_time_pair(CMD_ADD, {96{1'b1}}, {96{1'b1}});
		send_time_pair(CMD_SUB, '0, {16'h0, 64'h0, 16'h1});
		send_time_pair(CMD_SUB, {16'h1, 64'h0, 16'h0}, {16'h0, 64'h1, 16'h1});
		send_time_pair(CMD_SUB, {96{1'b1}}, {96{1'b1}});
	endtask

	task automatic test_halve_compare();
		send_time_pair(CMD_HALVE, {16'h0001, 64'h1, 16'h0}, '0);
		send_time_pair(CMD_HALVE, {96{1'b1}}, '0);
		send_time_pair(CMD_CMP, {96{1'b1}}, {96{1'b1}});
		send_time_pair(CMD_CMP, {16'h2, 64'h0, 16'h0}, {16'h1, {64{1'b1}}, 16'hFFFF});
		send_time_pair(CMD_CMP, {16'h1, 64'h5, 16'h0}, {16'h1, 64'h6, 16'h0});
		send_time_pair(CMD_CMP, {16'h1, 64'h5, 16'h3}, {16'h1, 64'h5, 16'h2});
	endtask

	// Exact multiples, the largest non-saturating quotient, seconds overflow,
	// and timestamps whose nanoseconds reach or pass one second.
	task automatic test_timestamps();
		send_stamp(CMD_TO_TS, 64'd0, '0, '0);
		send_stamp(CMD_TO_TS, 64'd999999999, '0, '0);
		send_stamp(CMD_TO_TS, 64'hFFFF_FFFF * BILLION + 64'd999999999, '0, '0);
		send_stamp(CMD_TO_TS, 64'h1_0000_0000 * BILLION, '0, '0);
		send_stamp(CMD_TO_TS, {64{1'b1}}, '0, '0);
		send_stamp(CMD_FROM_TS, '0, 32'hFFFF_FFFF, 30'd999999999);
		send_stamp(CMD_FROM_TS, '0, 32'd7, 30'd1000000000);
		send_stamp(CMD_FROM_TS, '0, 32'hFFFF_FFFF, {30{1'b1}});
		send_stamp(CMD_FROM_TS, '0, '0, '0);
	endtask

	task automatic test_spare_cmds();
		alu_op_t o;
		o = '{CMD_SPARE_6, '1, '1, '1, '1, '1, '1, '1, '1};
		send_op(o);
		o.op = CMD_SPARE_7;
		send_op(o);
	endtask

	// Random operations over every command. Part of the run is done without
	// any idling, and once the sender holds off until the pipeline is empty.
	task automatic test_random_mix();
		alu_op_t o;
		for (int i = 0; i < RANDOM_OPS; i++) begin
			steady = (i >= 200 && i < 320);
			if (i == 450) begin
				in_valid <= 1'b0;
				wait (pending_results.size() == 0);
				@(negedge clk);
			end
			o.op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
				: 3'($urandom_range(CMD_FROM_TS));
			o.ah = ($urandom_range(3) == 0) ? rand_part() : 16'($urandom());
			o.an = rand_ns();
			o.as_ = rand_part();
			o.bh = ($urandom_range(3) == 0) ? o.ah : 16'($urandom());
			o.bn = ($urandom_range(3) == 0) ? o.an : rand_ns();
			o.bs = ($urandom_range(3) == 0) ? o.as_ : rand_part();
			// Keep most conversions below the seconds saturation point.
			if (o.op == CMD_TO_TS && $urandom_range(3) != 0) begin
				o.an = 64'($urandom()) * BILLION + 64'($urandom_range(999999999));
			end
			o.sec = $urandom();
			o.nano = ($urandom_range(7) == 0) ? 30'($urandom())
				: 30'($urandom_range(999999999));
			send_op(o);
		end
		in_valid <= 1'b0;
		steady = 1'b0;
	endtask

	// Random output stalls, switched off during the steady stretch.
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 22);
	end

	// Compare each result leaving the block with the oldest prediction.
	always @(posedge clk) begin
		alu_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{r_high_ns, r_ns, r_sub_ns, order, stamp_seconds_out, stamp_nanos_out};
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d mismatch", results_seen);
						$display("  expected hi=%h ns=%h sub=%h ord=%0d sec=%h nano=%h",
							want.hi, want.ns, want.sub, want.ord, want.sec, want.nano);
						$display("  actual   hi=%h ns=%h sub=%h ord=%0d sec=%h nano=%h",
							got.hi, got.ns, got.sub, got.ord, got.sec, got.nano);
					end
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_add_sub();
		test_halve_compare();
		test_timestamps();
		test_spare_cmds();
		test_random_mix();
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d operations across all six commands and the spare codes,",
			ops_sent);
		$display("checked %0d results under random idling and stalls.", results_seen);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/tsa_pkg.sv
hdl/tsa_front.sv
hdl/tsa_div_stage.sv
hdl/scaled_ns_time_alu_top.sv
hdl/tsa_checker.sv
tb/sv/scaled_ns_time_alu_top_tb.sv
